### sv/ccs_pkg.sv
// Shared constants, scan mode codes and result types for the C comment
// and literal stripper. No dependencies.
package ccs_pkg;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NONE   = 8'h00;

  localparam logic [2:0] MODE_NORMAL     = 3'd0;
  localparam logic [2:0] MODE_SLASH      = 3'd1;
  localparam logic [2:0] MODE_BLOCK      = 3'd2;
  localparam logic [2:0] MODE_BLOCK_STAR = 3'd3;
  localparam logic [2:0] MODE_LINE       = 3'd4;
  localparam logic [2:0] MODE_LIT        = 3'd5;
  localparam logic [2:0] MODE_LIT_ESC    = 3'd6;

  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } res_t;

  // Results caused by one item, entry 0 goes out first.
  typedef struct packed {
    res_t [MAX_RES-1:0] ent;
    logic [1:0]         cnt;
  } res_bundle_t;

endpackage

### sv/c_comment_string_stripper_core.sv
// Top level of the C comment and literal stripper: scan stage plus result
// register. Depends on ccs_pkg, ccs_scan and ccs_obuf.
//
// Source bytes enter on the in_ channel, one item per byte, with
// in_end_of_text on the final byte of a text. Cleaned text leaves on the
// out_ channel: block comments vanish except for their newlines, line
// comments vanish up to (not including) their newline, and each string or
// character literal becomes a space where it opens and one where it closes,
// keeping its newlines. A slash is held until the next byte shows whether it
// opens a comment. The last result of a text carries out_last; a final byte
// that yields no text gives one result with out_has_byte low. After the end
// byte the scanner is back in plain text mode for the next text. Rate: an
// item is taken every cycle as long as out_ready stays high and each byte
// produces at most one result; a byte producing k results (k up to three,
// e.g. a held slash followed by a quote at end of text) fills that many
// entries of the three-entry result register, and the input is held until
// only its last result remains and is being taken on the out_ channel.
module c_comment_string_stripper_core
  import ccs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_last
);

  logic        accept;
  res_bundle_t scan_res;
  res_t        head;

  // take a byte only when the result register is, or is about to be, empty
  assign accept = in_valid && in_ready;

  ccs_scan u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .res            (scan_res)
  );

  ccs_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res       (scan_res),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_byte     = head.data;
  assign out_has_byte = head.has_byte;
  assign out_last     = head.last;

  // An end byte always yields at least one result.
  a_end_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_end_of_text |-> scan_res.cnt != 2'd0)
    else $error("end of text produced no result");

  // Results of an end byte show up on the next cycle.
  a_end_drains: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_end_of_text |=> out_valid)
    else $error("no result after end of text item");

  // The empty marker only ever closes a text.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_last)
    else $error("empty result without last flag");

  // No byte is taken while results of the previous one would be overwritten.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while results still pending");

endmodule

### sv/ccs_scan.sv
// Scan state and per-byte decode: turns one accepted item into zero to
// three results. Depends on ccs_pkg.
module ccs_scan
  import ccs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_text,
  output res_bundle_t res
);

  logic [2:0] mode_r, mode_nxt;
  logic       quote_single_r, quote_single_nxt;

  always_comb begin
    logic       do_normal;
    logic [7:0] quote_ch;
    res         = '0;
    mode_nxt    = mode_r;
    quote_single_nxt = quote_single_r;
    do_normal   = 1'b0;
    quote_ch    = quote_single_r ? CH_SQUOTE : CH_DQUOTE;

    unique case (mode_r)
      MODE_SLASH: begin
        if (in_byte == CH_STAR) begin
          mode_nxt = MODE_BLOCK;
        end else if (in_byte == CH_SLASH) begin
          mode_nxt = MODE_LINE;
        end else begin
          res.ent[res.cnt] = '{data: CH_SLASH, has_byte: 1'b1, last: 1'b0};
          res.cnt = res.cnt + 2'd1;
          do_normal = 1'b1;
        end
      end
      MODE_BLOCK, MODE_BLOCK_STAR: begin
        if (in_byte == CH_SLASH && mode_r == MODE_BLOCK_STAR) begin
          mode_nxt = MODE_NORMAL;
        end else if (in_byte == CH_STAR) begin
          mode_nxt = MODE_BLOCK_STAR;
        end else begin
          if (in_byte == CH_NL) begin
            res.ent[res.cnt] = '{data: CH_NL, has_byte: 1'b1, last: 1'b0};
            res.cnt = res.cnt + 2'd1;
          end
          mode_nxt = MODE_BLOCK;
        end
      end
      MODE_LINE: begin
        if (in_byte == CH_NL) begin
          res.ent[res.cnt] = '{data: CH_NL, has_byte: 1'b1, last: 1'b0};
          res.cnt = res.cnt + 2'd1;
          mode_nxt = MODE_NORMAL;
        end
      end
      MODE_LIT: begin
        if (in_byte == CH_BSLASH) begin
          mode_nxt = MODE_LIT_ESC;
        end else if (in_byte == quote_ch) begin
          res.ent[res.cnt] = '{data: CH_SPACE, has_byte: 1'b1, last: 1'b0};
          res.cnt = res.cnt + 2'd1;
          mode_nxt = MODE_NORMAL;
        end else if (in_byte == CH_NL) begin
          res.ent[res.cnt] = '{data: CH_NL, has_byte: 1'b1, last: 1'b0};
          res.cnt = res.cnt + 2'd1;
        end
      end
      MODE_LIT_ESC: begin
        mode_nxt = MODE_LIT;
      end
      default: begin
        do_normal = 1'b1;
      end
    endcase

    if (do_normal) begin
      if (in_byte == CH_SLASH) begin
        mode_nxt = MODE_SLASH;
      end else if (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE) begin
        res.ent[res.cnt] = '{data: CH_SPACE, has_byte: 1'b1, last: 1'b0};
        res.cnt = res.cnt + 2'd1;
        quote_single_nxt = (in_byte == CH_SQUOTE);
        mode_nxt = MODE_LIT;
      end else begin
        res.ent[res.cnt] = '{data: in_byte, has_byte: 1'b1, last: 1'b0};
        res.cnt = res.cnt + 2'd1;
        mode_nxt = MODE_NORMAL;
      end
    end

    // End of text: flush a held slash, close an open literal, mark last (or emit the empty last marker).
    if (in_end_of_text) begin
      if (mode_nxt == MODE_SLASH) begin
        res.ent[res.cnt] = '{data: CH_SLASH, has_byte: 1'b1, last: 1'b0};
        res.cnt = res.cnt + 2'd1;
      end else if (mode_nxt == MODE_LIT || mode_nxt == MODE_LIT_ESC) begin
        res.ent[res.cnt] = '{data: CH_SPACE, has_byte: 1'b1, last: 1'b0};
        res.cnt = res.cnt + 2'd1;
      end
      if (res.cnt == 2'd0) begin
        res.ent[0] = '{data: CH_NONE, has_byte: 1'b0, last: 1'b1};
        res.cnt = 2'd1;
      end else begin
        res.ent[res.cnt - 2'd1].last = 1'b1;
      end
      mode_nxt = MODE_NORMAL;
      quote_single_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_NORMAL;
      quote_single_r <= 1'b0;
    end else if (accept) begin
      mode_r         <= mode_nxt;
      quote_single_r <= quote_single_nxt;
    end
  end

endmodule

### sv/ccs_obuf.sv
// Result register: holds up to three results of one item and drains them
// one per cycle while out_ready is high. Depends on ccs_pkg.
module ccs_obuf
  import ccs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  res_bundle_t res,
  output logic        can_load,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        head
);

  res_t [MAX_RES-1:0] ent_r, ent_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign can_load  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign head      = ent_r[0];

  always_comb begin
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (load) begin
      ent_nxt = res.ent;
      cnt_nxt = res.cnt;
    end else if (pop) begin
      // advance the queue by one entry
      ent_nxt[0] = ent_r[1];
      ent_nxt[1] = ent_r[2];
      cnt_nxt    = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
